>>> src/rau_pkg.sv
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_COMB,
    S_GCD, S_GWAIT, S_DNUM, S_DDEN, S_CHECK, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

>>> src/rau_div.sv
module rau_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::div_req_t  req,
  output rau_pkg::div_rsp_t  rsp
);

  logic [63:0] q_r, q_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {r_r, q_r[63]};
    trial    = shifted - {1'b0, d_r};
    if (req.start) begin
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = shifted[63:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule

>>> src/rational_arithmetic_unit.sv
// Channel | Ports                      | Item
// in      | in_tvalid/tready/tdata/user | operands (tdata), op (tuser)
// out     | out_tvalid/tready/tdata     | result num, den, status
// One item at a time. Cross products go through a registered 32x32 multiplier,
// then Euclid's gcd on a shared 64-step restoring divider, then two more
// divisions by the gcd.
// Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
// in_tready is high only when idle; a result waits in place until taken.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // first_num, first_den, second_num, second_den
  input  logic [127:0]  in_tdata,
  // op
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // result_num, result_den, status
  output logic [71:0]   out_tdata
);

  rau_pkg::state_t state_r, state_nxt;

  logic [1:0]  op_r;
  logic [31:0] ma_r, mb_r, mc_r, md_r;
  logic        s1_r, s2_r;
  logic [63:0] p_r;
  logic [63:0] t1_r, t2_r, den_r, num_r;
  logic        neg_r;
  logic [63:0] gx_r, gy_r;
  logic [31:0] rnum_r;
  logic [30:0] rden_r;
  logic [1:0]  st_r;
  logic        wait_r;

  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = ma_r;
    mul_b = md_r;
    unique case (state_r)
      rau_pkg::S_MUL0: begin
        mul_a = ma_r;
        mul_b = (op_r == rau_pkg::OP_MUL) ? mc_r : md_r;
      end
      rau_pkg::S_MUL1: begin
        mul_a = mb_r;
        mul_b = (op_r == rau_pkg::OP_DIV) ? mc_r : md_r;
      end
      rau_pkg::S_MUL2: begin
        mul_a = mc_r;
        mul_b = mb_r;
      end
      default: begin
        mul_a = ma_r;
        mul_b = md_r;
      end
    endcase
  end

  logic [63:0] lim;
  assign lim = 64'd1 << (WIDTH - 1);

  logic n1, n2, n2s;
  always_comb begin
    n1  = s1_r && (t1_r != 64'd0);
    n2s = s2_r && (t2_r != 64'd0);
    n2  = (op_r == rau_pkg::OP_SUB) ? (!n2s && (t2_r != 64'd0)) : n2s;
  end

  always_comb begin
    state_nxt     = state_r;
    dreq.start    = 1'b0;
    dreq.dividend = gx_r;
    dreq.divisor  = gy_r;
    unique case (state_r)
      rau_pkg::S_IDLE:  if (in_tvalid) state_nxt = rau_pkg::S_MUL0;
      rau_pkg::S_MUL0:  state_nxt = (mb_r == 32'd0 || md_r == 32'd0 ||
                 (op_r == rau_pkg::OP_DIV && mc_r == 32'd0)) ? rau_pkg::S_OUT : rau_pkg::S_MUL1;
      rau_pkg::S_MUL1:  state_nxt = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2:  state_nxt = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3:  state_nxt = rau_pkg::S_COMB;
      rau_pkg::S_COMB:  state_nxt = rau_pkg::S_GCD;
      rau_pkg::S_GCD: begin
        if (num_r == 64'd0) state_nxt = rau_pkg::S_OUT;
        else if (gy_r == 64'd0) begin
          dreq.start = 1'b1; dreq.dividend = num_r; dreq.divisor = gx_r;
          state_nxt = rau_pkg::S_DNUM;
        end else begin
          dreq.start = 1'b1; state_nxt = rau_pkg::S_GWAIT;
        end
      end
      rau_pkg::S_GWAIT: if (drsp.done) state_nxt = rau_pkg::S_GCD;
      rau_pkg::S_DNUM: if (drsp.done && !wait_r) begin
        dreq.start = 1'b1; dreq.dividend = den_r; dreq.divisor = gx_r;
        state_nxt = rau_pkg::S_DDEN;
      end
      rau_pkg::S_DDEN:  if (drsp.done && !wait_r) state_nxt = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK: state_nxt = rau_pkg::S_OUT;
      rau_pkg::S_OUT:   if (out_tready) state_nxt = rau_pkg::S_IDLE;
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= {32'd0, mul_a} * {32'd0, mul_b};
    wait_r <= dreq.start;
    unique case (state_r)
      rau_pkg::S_IDLE: if (in_tvalid) begin
        op_r <= in_tuser;
        ma_r <= mag32(in_tdata[31:0]);
        mb_r <= mag32(in_tdata[63:32]);
        mc_r <= mag32(in_tdata[95:64]);
        md_r <= mag32(in_tdata[127:96]);
        s1_r <= in_tdata[31] ^ in_tdata[63];
        s2_r <= in_tdata[95] ^ in_tdata[127];
        rnum_r <= '0; rden_r <= '0; st_r <= rau_pkg::ST_OK;
      end
      rau_pkg::S_MUL0: if (mb_r == 32'd0 || md_r == 32'd0 ||
                  (op_r == rau_pkg::OP_DIV && mc_r == 32'd0)) st_r <= rau_pkg::ST_ZERO;
      rau_pkg::S_MUL1: t1_r <= p_r;
      rau_pkg::S_MUL2: den_r <= p_r;
      rau_pkg::S_MUL3: t2_r <= p_r;
      rau_pkg::S_COMB: begin
        if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) begin
          num_r <= t1_r; den_r <= den_r; neg_r <= s1_r ^ s2_r;
        end else if (n1 == n2) begin
          num_r <= t1_r + t2_r; neg_r <= n1;
        end else if (t1_r >= t2_r) begin
          num_r <= t1_r - t2_r; neg_r <= n1;
        end else begin
          num_r <= t2_r - t1_r; neg_r <= n2;
        end
        if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) begin
          gx_r <= t1_r; gy_r <= den_r;
        end else if (n1 == n2) begin
          gx_r <= t1_r + t2_r; gy_r <= den_r;
        end else if (t1_r >= t2_r) begin
          gx_r <= t1_r - t2_r; gy_r <= den_r;
        end else begin
          gx_r <= t2_r - t1_r; gy_r <= den_r;
        end
      end
      rau_pkg::S_GCD: if (num_r == 64'd0) rden_r <= 31'd1;
      rau_pkg::S_GWAIT: if (drsp.done) begin gx_r <= gy_r; gy_r <= drsp.rem; end
      rau_pkg::S_DNUM: if (drsp.done && !wait_r) num_r <= drsp.quot;
      rau_pkg::S_DDEN: if (drsp.done && !wait_r) den_r <= drsp.quot;
      rau_pkg::S_CHECK: begin
        if (den_r > lim - 64'd1 || (neg_r ? num_r > lim : num_r > lim - 64'd1)) begin
          st_r <= rau_pkg::ST_OVF;
        end else begin
          rnum_r <= neg_r ? (32'd0 - num_r[31:0]) : num_r[31:0];
          rden_r <= den_r[30:0];
        end
      end
      default: ;
    endcase
    if (!rst_n) state_r <= rau_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_tready  = (state_r == rau_pkg::S_IDLE);
  assign out_tvalid = (state_r == rau_pkg::S_OUT);
  assign out_tdata  = {7'd0, st_r, rden_r, rnum_r};

endmodule

>>> dv/tb_rational_arithmetic_unit.sv
module tb_rational_arithmetic_unit;

  typedef struct {
    logic [31:0]      num;
    logic [30:0]      den;
    rau_pkg::status_t st;
  } frac_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;

  frac_result_t pending_results[$];
  int           mismatch_cnt = 0;
  int           hold_off_cycles;
  bit           hold_off_req = 1'b0;
  bit           hold_off_taken;
  bit           stall_enable;

  rational_arithmetic_unit #(.WIDTH(32)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] mag32(logic [31:0] v);
    return v[31] ? {32'd0, -v} : {32'd0, v};
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic frac_result_t rational_result(rau_pkg::op_t op, logic [31:0] an,
                                                   logic [31:0] ad, logic [31:0] bn,
                                                   logic [31:0] bd);
    frac_result_t res;
    logic [63:0] ma, mb, mc, md, num, den, t1, t2, g;
    logic s1, s2, n1, n2, neg;
    ma = mag32(an);
    mb = mag32(ad);
    mc = mag32(bn);
    md = mag32(bd);
    s1 = an[31] ^ ad[31];
    s2 = bn[31] ^ bd[31];
    res.num = '0;
    res.den = '0;
    res.st = rau_pkg::ST_OK;
    if (mb == 0 || md == 0 || (op == rau_pkg::OP_DIV && mc == 0)) begin
      res.st = rau_pkg::ST_ZERO;
      return res;
    end
    if (op == rau_pkg::OP_MUL) begin
      num = ma * mc;
      den = mb * md;
      neg = s1 ^ s2;
    end else if (op == rau_pkg::OP_DIV) begin
      num = ma * md;
      den = mb * mc;
      neg = s1 ^ s2;
    end else begin
      t1 = ma * md;
      t2 = mc * mb;
      n1 = s1 && t1 != 0;
      n2 = s2 && t2 != 0;
      if (op == rau_pkg::OP_SUB) n2 = !n2 && t2 != 0;
      den = mb * md;
      if (n1 == n2) begin
        num = t1 + t2;
        neg = n1;
      end else if (t1 >= t2) begin
        num = t1 - t2;
        neg = n1;
      end else begin
        num = t2 - t1;
        neg = n2;
      end
    end
    if (num == 0) begin
      res.den = 31'd1;
      return res;
    end
    g = euclid(num, den);
    num = num / g;
    den = den / g;
    if (den > 64'h7FFF_FFFF || (neg ? num > 64'h8000_0000 : num > 64'h7FFF_FFFF)) begin
      res.st = rau_pkg::ST_OVF;
      return res;
    end
    res.num = neg ? -num[31:0] : num[31:0];
    res.den = den[30:0];
    return res;
  endfunction

  task automatic send_item(rau_pkg::op_t op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    in_tvalid <= 1'b1;
    in_tdata  <= {bd, bn, ad, an};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(rational_result(op, an, ad, bn, bd));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom;
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($urandom_range(1, 100)) * 32'($urandom_range(1, 100));
    endcase
  endfunction

  always @(posedge clk) begin
    frac_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result item %h", out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[31:0] !== exp_r.num || out_tdata[62:32] !== exp_r.den ||
            out_tdata[64:63] !== exp_r.st) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp num %h den %h st %0d, got num %h den %h st %0d",
                     exp_r.num, exp_r.den, exp_r.st, out_tdata[31:0], out_tdata[62:32],
                     out_tdata[64:63]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_taken <= 1'b0;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      hold_off_cycles <= 20000;
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else if (stall_enable) begin
      out_tready <= ($urandom_range(0, 7) > 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    rau_pkg::op_t ops[4] = '{rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
                             rau_pkg::OP_DIV};
    foreach (ops[i]) begin
      send_item(ops[i], 32'd1, 32'd2, 32'd1, 32'd3);
      send_item(ops[i], 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(ops[i], 32'd5, 32'd0, 32'd1, 32'd1);
      send_item(ops[i], 32'd0, 32'hFFFF_FFFD, 32'd0, 32'd7);
    end
    send_item(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd0, 32'd9);
    send_item(rau_pkg::OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0);
    send_item(rau_pkg::OP_SUB, 32'd3, 32'd4, 32'hFFFF_FFFD, 32'hFFFF_FFFC);
    send_item(rau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1);
    send_item(rau_pkg::OP_DIV, 32'd1, 32'h7FFF_FFFF, 32'd2, 32'd1);
    send_item(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
    send_item(rau_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      send_item(rau_pkg::op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
      idle_gap();
    end
  endtask

  task automatic test_back_pressure();
    hold_off_req = 1'b1;
    repeat (6) send_item(rau_pkg::op_t'($urandom_range(0, 3)), rand_operand(),
                         rand_operand(), rand_operand(), rand_operand());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    stall_enable = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_enable = 1'b1;
    test_random(700);
    test_back_pressure();
    stall_enable = 1'b0;
    test_random(400);
    stall_enable = 1'b1;
    test_random(400);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000000;
    $display("rational_arithmetic_unit regression: fail");
    $finish;
  end

endmodule
